[rtl/kars_pkg.sv]
// Package for the keepalive/reconnect supervisor.
// Holds the command and action codes, constants and the transfer payload types.
// No dependencies.
`default_nettype none

package kars_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW  = 12;
  localparam int unsigned IdxW  = 2;

  localparam logic [TimeW-1:0] ShortConnS   = 32'd60;
  localparam logic [CfgW-1:0]  MaxIntervalS = 12'd300;
  localparam logic [CfgW-1:0]  MinTimeoutS  = 12'd5;
  localparam logic [CfgW-1:0]  RstTimeoutS  = 12'd10;
  localparam logic [CfgW-1:0]  RstBackoff   = 12'd512;

  typedef enum logic [2:0] {
    CMD_TICK     = 3'd0,
    CMD_CONN_OK  = 3'd1,
    CMD_CONN_ERR = 3'd2,
    CMD_RX_PKT   = 3'd3,
    CMD_SOCK_ERR = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_CONNECT   = 3'd1,
    ACT_PING      = 3'd2,
    ACT_TIMEOUT   = 3'd3,
    ACT_CONNECTED = 3'd4,
    ACT_CONN_FAIL = 3'd5,
    ACT_LINK_ERR  = 3'd6
  } action_e;

  typedef enum logic [IdxW-1:0] {
    REG_IDLE_TIMEOUT = 2'd0,
    REG_BACKOFF      = 2'd1
  } reg_idx_e;

  typedef struct packed {
    logic [CfgW-1:0] idle_timeout_s;
    logic [CfgW-1:0] backoff_factor;
  } cfg_t;

  typedef struct packed {
    logic [2:0]       command;
    logic [TimeW-1:0] now_s;
  } item_t;

  typedef struct packed {
    logic [2:0]       action;
    logic             link_up;
    logic [TimeW-1:0] retry_at_s;
  } result_t;

endpackage

`default_nettype wire

[rtl/kars_if.sv]
// Valid/ready channel interfaces for the supervisor's event and result streams.
// Depends on kars_pkg.
`default_nettype none

interface kars_in_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                command;
  logic [kars_pkg::TimeW-1:0] now_s;

  modport source (output valid, output command, output now_s, input ready);
  modport sink   (input valid, input command, input now_s, output ready);
endinterface

interface kars_out_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                action;
  logic                      link_up;
  logic [kars_pkg::TimeW-1:0] retry_at_s;

  modport source (output valid, output action, output link_up, output retry_at_s, input ready);
  modport sink   (input valid, input action, input link_up, input retry_at_s, output ready);
endinterface

`default_nettype wire

[rtl/kars_cfg.sv]
// Configuration registers of the supervisor (idle timeout, backoff factor).
// Depends on kars_pkg.
`default_nettype none

module kars_cfg (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     we_i,
  input  wire logic [kars_pkg::IdxW-1:0] index_i,
  input  wire logic [kars_pkg::CfgW-1:0] wdata_i,
  output kars_pkg::cfg_t                 cfg_o
);
  import kars_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (reg_idx_e'(index_i))
        REG_IDLE_TIMEOUT: begin
          // timeout is floored at the minimum on write
          cfg_d.idle_timeout_s = (wdata_i < MinTimeoutS) ? MinTimeoutS : wdata_i;
        end
        REG_BACKOFF: cfg_d.backoff_factor = wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.idle_timeout_s <= RstTimeoutS;
      cfg_q.backoff_factor <= RstBackoff;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[rtl/kars_core.sv]
// Link state registers and the per-event update logic with retry backoff.
// Depends on kars_pkg.
`default_nettype none

module kars_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  step_i,
  input  wire kars_pkg::item_t item_i,
  input  wire kars_pkg::cfg_t  cfg_i,
  output kars_pkg::result_t result_o
);
  import kars_pkg::*;

  logic             connected_q, connected_d;
  logic             connecting_q, connecting_d;
  logic [TimeW-1:0] last_attempt_q, last_attempt_d;
  logic [TimeW-1:0] last_activity_q, last_activity_d;
  logic [TimeW-1:0] next_retry_q, next_retry_d;
  logic [CfgW-1:0]  interval_q, interval_d;

  logic             up;
  logic             short_conn;
  logic             idle_expired;
  logic [TimeW:0]   attempt_limit;
  logic [TimeW:0]   idle_limit;
  logic [2*CfgW-1:0] product;
  logic [2*CfgW-9:0] grown;
  logic [CfgW-1:0]  grown_capped;
  logic [TimeW-1:0] sched_retry;
  logic [CfgW-1:0]  sched_interval;
  action_e          action;

  assign up            = connected_q && !connecting_q;
  assign attempt_limit = {1'b0, last_attempt_q} + {1'b0, ShortConnS};
  assign idle_limit    = {1'b0, last_activity_q} + {{(TimeW-CfgW+1){1'b0}}, cfg_i.idle_timeout_s};
  assign short_conn    = attempt_limit >= {1'b0, item_i.now_s};
  assign idle_expired  = idle_limit < {1'b0, item_i.now_s};

  assign product      = cfg_i.backoff_factor * interval_q;
  assign grown        = product[2*CfgW-1:8];
  assign grown_capped = (grown < {{(CfgW-8){1'b0}}, MaxIntervalS}) ? grown[CfgW-1:0]
                                                                   : MaxIntervalS;

  // retry after failure or drop: backoff if short-lived, else at once
  always_comb begin
    if (short_conn) begin
      sched_retry    = item_i.now_s + {{(TimeW-CfgW){1'b0}}, interval_q};
      sched_interval = grown_capped;
    end else begin
      sched_retry    = '0;
      sched_interval = cfg_i.idle_timeout_s;
    end
  end

  always_comb begin
    connected_d     = connected_q;
    connecting_d    = connecting_q;
    last_attempt_d  = last_attempt_q;
    last_activity_d = last_activity_q;
    next_retry_d    = next_retry_q;
    interval_d      = interval_q;
    action          = ACT_NONE;
    case (cmd_e'(item_i.command))
      CMD_TICK: begin
        if (up && idle_expired) begin
          next_retry_d = sched_retry;
          interval_d   = sched_interval;
          connected_d  = 1'b0;
          action       = ACT_TIMEOUT;
        end else if (up) begin
          action = ACT_PING;
        end else if (!connecting_q && next_retry_q <= item_i.now_s) begin
          last_attempt_d  = item_i.now_s;
          last_activity_d = item_i.now_s;
          connected_d     = 1'b0;
          connecting_d    = 1'b1;
          action          = ACT_CONNECT;
        end
      end
      CMD_CONN_OK: begin
        if (connecting_q) begin
          connecting_d = 1'b0;
          connected_d  = 1'b1;
          action       = ACT_CONNECTED;
        end
      end
      CMD_CONN_ERR: begin
        if (connecting_q) begin
          next_retry_d = sched_retry;
          interval_d   = sched_interval;
          connecting_d = 1'b0;
          connected_d  = 1'b0;
          action       = ACT_CONN_FAIL;
        end
      end
      CMD_RX_PKT: last_activity_d = item_i.now_s;
      CMD_SOCK_ERR: begin
        next_retry_d = sched_retry;
        interval_d   = sched_interval;
        connecting_d = 1'b0;
        connected_d  = 1'b0;
        action       = ACT_LINK_ERR;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      connected_q     <= 1'b0;
      connecting_q    <= 1'b0;
      last_attempt_q  <= '0;
      last_activity_q <= '0;
      next_retry_q    <= '0;
      interval_q      <= RstTimeoutS;
    end else if (step_i) begin
      connected_q     <= connected_d;
      connecting_q    <= connecting_d;
      last_attempt_q  <= last_attempt_d;
      last_activity_q <= last_activity_d;
      next_retry_q    <= next_retry_d;
      interval_q      <= interval_d;
    end
  end

  assign result_o.action     = action;
  assign result_o.link_up    = connected_d && !connecting_d;
  assign result_o.retry_at_s = next_retry_d;

endmodule

`default_nettype wire

[rtl/keepalive_reconnect_supervisor.sv]
// Keepalive/reconnect supervisor: event register, state update, result register.
// Depends on kars_pkg, kars_if, kars_cfg and kars_core.
//
// Usage: events (command, now_s) arrive on in_i; one result (action, link_up,
// retry_at_s) per event leaves on out_o in event order. Both are valid/ready
// channels; a transfer happens at a clock edge with valid and ready high.
// Configuration is a write-only port (cfg_we_i, cfg_index_i, cfg_wdata_i):
// index 0 idle timeout (floored at 5), index 1 Q4.8 backoff factor; other
// indexes are dropped. Write only while no event is in flight.
// Path: an event is held in the event register, stepped through the state update
// and then held in the result register for out_o. Throughput: one event per cycle
// while out_o.ready is high, bounded by the single state-update step between the two registers.
// Reset (rst_ni low, asynchronous) clears the link state, loads timeout 10
// and backoff 2.0, and empties both registers.
// Stall: when out_o.ready is low the result register holds; one more event
// can still be taken into the event register, then in_i.ready drops.
`default_nettype none

module keepalive_reconnect_supervisor (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  kars_in_if.sink                        in_i,
  kars_out_if.source                     out_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [kars_pkg::IdxW-1:0] cfg_index_i,
  input  wire logic [kars_pkg::CfgW-1:0] cfg_wdata_i
);
  import kars_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  logic    item_vld_q;
  result_t res_q, res_d;
  logic    res_vld_q;
  logic    step;

  assign step       = item_vld_q && (!res_vld_q || out_o.ready);
  assign in_i.ready = !item_vld_q || step;

  kars_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .index_i (cfg_index_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  kars_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      if (in_i.ready) begin
        item_vld_q <= in_i.valid;
      end
      if (step) begin
        res_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.command <= in_i.command;
      item_q.now_s   <= in_i.now_s;
    end
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid      = res_vld_q;
  assign out_o.action     = res_q.action;
  assign out_o.link_up    = res_q.link_up;
  assign out_o.retry_at_s = res_q.retry_at_s;

endmodule

`default_nettype wire

[dv/kars_checker.sv]
`timescale 1ns / 100ps
// Checker for the keepalive/reconnect supervisor: tracks config writes and event
// transfers, predicts each result and compares it with the result stream.
// Depends on kars_pkg and kars_if.

module kars_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  kars_in_if          evt_ch,
  kars_out_if         res_ch,
  input  logic        cfg_we_i,
  input  logic [kars_pkg::IdxW-1:0] cfg_index_i,
  input  logic [kars_pkg::CfgW-1:0] cfg_wdata_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import kars_pkg::*;

  localparam int unsigned ReportMax = 10;

  // shadow of the supervisor's registers and link state
  logic [CfgW-1:0]  m_timeout_s;
  logic [CfgW-1:0]  m_backoff;
  logic             m_connected;
  logic             m_connecting;
  logic [TimeW-1:0] m_attempt_s;
  logic [TimeW-1:0] m_activity_s;
  logic [TimeW-1:0] m_retry_s;
  logic [CfgW-1:0]  m_interval_s;

  result_t     pending_results[$];
  int unsigned fails;
  int unsigned results_seen;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    fails        = 0;
    results_seen = 0;
  end

  task automatic clear_link();
    m_timeout_s  = RstTimeoutS;
    m_backoff    = RstBackoff;
    m_connected  = 1'b0;
    m_connecting = 1'b0;
    m_attempt_s  = '0;
    m_activity_s = '0;
    m_retry_s    = '0;
    m_interval_s = RstTimeoutS;
  endtask

  // backoff on a short-lived connection, otherwise restart from the base interval
  task automatic plan_retry(input logic [TimeW-1:0] now);
    logic [TimeW:0] limit;
    logic [23:0]    grown;
    limit = {1'b0, m_attempt_s} + 33'(ShortConnS);
    if (limit >= {1'b0, now}) begin
      m_retry_s    = now + 32'(m_interval_s);
      grown        = (24'(m_backoff) * 24'(m_interval_s)) >> 8;
      m_interval_s = (grown < 24'(MaxIntervalS)) ? grown[CfgW-1:0] : MaxIntervalS;
    end else begin
      m_interval_s = m_timeout_s;
      m_retry_s    = '0;
    end
  endtask

  task automatic apply_event(input item_t ev, output result_t res);
    action_e        act;
    logic           up;
    logic [TimeW:0] idle_end;
    act      = ACT_NONE;
    up       = m_connected && !m_connecting;
    idle_end = {1'b0, m_activity_s} + 33'(m_timeout_s);
    case (ev.command)
      CMD_TICK: begin
        if (up && idle_end < {1'b0, ev.now_s}) begin
          plan_retry(ev.now_s);
          m_connected = 1'b0;
          act = ACT_TIMEOUT;
        end else if (up) begin
          act = ACT_PING;
        end else if (!m_connecting && m_retry_s <= ev.now_s) begin
          m_attempt_s  = ev.now_s;
          m_activity_s = ev.now_s;
          m_connected  = 1'b0;
          m_connecting = 1'b1;
          act = ACT_CONNECT;
        end
      end
      CMD_CONN_OK: begin
        if (m_connecting) begin
          m_connecting = 1'b0;
          m_connected  = 1'b1;
          act = ACT_CONNECTED;
        end
      end
      CMD_CONN_ERR: begin
        if (m_connecting) begin
          plan_retry(ev.now_s);
          m_connecting = 1'b0;
          m_connected  = 1'b0;
          act = ACT_CONN_FAIL;
        end
      end
      CMD_RX_PKT: m_activity_s = ev.now_s;
      CMD_SOCK_ERR: begin
        plan_retry(ev.now_s);
        m_connecting = 1'b0;
        m_connected  = 1'b0;
        act = ACT_LINK_ERR;
      end
      default: ;
    endcase
    res.action     = act;
    res.link_up    = m_connected && !m_connecting;
    res.retry_at_s = m_retry_s;
  endtask

  always @(posedge clk_i) begin : watch
    item_t   ev;
    result_t want;
    result_t got;
    if (!rst_ni) begin
      clear_link();
      pending_results.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_IDLE_TIMEOUT: m_timeout_s = (cfg_wdata_i < MinTimeoutS) ? MinTimeoutS : cfg_wdata_i;
          REG_BACKOFF:      m_backoff   = cfg_wdata_i;
          default: ;
        endcase
      end
      // the result side first: it always belongs to an older event
      if (res_ch.valid && res_ch.ready) begin
        got.action     = res_ch.action;
        got.link_up    = res_ch.link_up;
        got.retry_at_s = res_ch.retry_at_s;
        if (pending_results.size() == 0) begin
          if (fails < ReportMax)
            $display("result %0d with no event waiting: action=%0d link_up=%0b retry_at_s=%0h",
                     results_seen, got.action, got.link_up, got.retry_at_s);
          fails++;
        end else begin
          want = pending_results.pop_front();
          if (got.action !== want.action || got.link_up !== want.link_up ||
              got.retry_at_s !== want.retry_at_s) begin
            if (fails < ReportMax)
              $display({"result %0d mismatch: expected action=%0d link_up=%0b retry_at_s=%0h,",
                        " got action=%0d link_up=%0b retry_at_s=%0h"},
                       results_seen, want.action, want.link_up, want.retry_at_s,
                       got.action, got.link_up, got.retry_at_s);
            fails++;
          end
        end
        results_seen++;
      end
      if (evt_ch.valid && evt_ch.ready) begin
        ev.command = evt_ch.command;
        ev.now_s   = evt_ch.now_s;
        apply_event(ev, want);
        pending_results.push_back(want);
      end
    end
    fail_count_o <= fails;
    pending_o    <= pending_results.size();
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// Top of the supervisor testbench: clock, reset, event and config stimulus,
// result-side backpressure and the verdict. Depends on kars_pkg, kars_if, kars_checker.

module testbench;
  import kars_pkg::*;

  localparam int unsigned CycleLimit   = 600000;
  localparam int unsigned ItemsPerRun  = 225;
  localparam int unsigned PhaseCount   = 6;
  localparam int unsigned LongHold     = 400;
  localparam logic [2:0]  CmdSpareLo   = 3'd5;
  localparam logic [2:0]  CmdSpareHi   = 3'd7;
  localparam logic [IdxW-1:0] RegSpareLo = 2'd2;
  localparam logic [IdxW-1:0] RegSpareHi = 2'd3;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we;
  logic [IdxW-1:0] cfg_index;
  logic [CfgW-1:0] cfg_wdata;

  kars_in_if  evt_ch ();
  kars_out_if res_ch ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count;

  // idling controls for the stimulus and the result sink
  logic        src_eager;
  logic        sink_eager;
  int unsigned hold_requests;
  int unsigned hold_served;
  int unsigned hold_left;
  int unsigned run_left;

  logic [TimeW-1:0] t_now;

  keepalive_reconnect_supervisor dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (evt_ch),
    .out_o       (res_ch),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  kars_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .evt_ch       (evt_ch),
    .res_ch       (res_ch),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  // result sink: random stalls, eager stretches and long hold-offs on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else if (hold_requests != hold_served) begin
      hold_served++;
      hold_left = LongHold - 1;
      res_ch.ready <= 1'b0;
    end else if (run_left > 0) begin
      run_left--;
      res_ch.ready <= 1'b1;
    end else begin
      run_left  = $urandom_range(1, 12);
      hold_left = sink_eager ? 0 : gap_len();
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_event(input logic [2:0] cmd, input logic [TimeW-1:0] t);
    int unsigned gap;
    gap = src_eager ? 0 : gap_len();
    if (gap > 0) begin
      evt_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    evt_ch.valid   <= 1'b1;
    evt_ch.command <= cmd;
    evt_ch.now_s   <= t;
    @(posedge clk_i);
    while (!evt_ch.ready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    evt_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [CfgW-1:0] data);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
  endtask

  // real registers, then junk to the unused indexes, which must not stick
  task automatic load_config(input logic [CfgW-1:0] timeout, input logic [CfgW-1:0] factor);
    write_reg(REG_IDLE_TIMEOUT, timeout);
    write_reg(REG_BACKOFF, factor);
    write_reg(RegSpareLo, CfgW'($urandom));
    write_reg(RegSpareHi, CfgW'($urandom));
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic advance_clock();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) t_now += $urandom_range(0, 3);
    else if (r < 80) t_now += $urandom_range(4, 20);
    else if (r < 90) t_now += $urandom_range(21, 120);
    else if (r < 95) t_now += $urandom_range(121, 5000);
    else if (r < 98) t_now = $urandom();
    else t_now -= $urandom_range(1, 30);
  endtask

  function automatic logic [2:0] pick_command();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return CMD_TICK;
    else if (r < 58) return CMD_CONN_OK;
    else if (r < 68) return CMD_CONN_ERR;
    else if (r < 90) return CMD_RX_PKT;
    else if (r < 96) return CMD_SOCK_ERR;
    else return 3'($urandom_range(CmdSpareLo, CmdSpareHi));
  endfunction

  task automatic directed_walk();
    send_event(CMD_CONN_OK, 32'd0);    // connect results while idle are dropped
    send_event(CMD_CONN_ERR, 32'd0);
    send_event(CMD_RX_PKT, 32'd1);     // activity still noted while down
    for (int c = CmdSpareLo; c <= CmdSpareHi; c++) send_event(3'(c), 32'd2);
    send_event(CMD_TICK, 32'd3);
    send_event(CMD_TICK, 32'd3);       // still connecting
    send_event(CMD_CONN_OK, 32'd4);
    send_event(CMD_TICK, 32'd5);
    send_event(CMD_RX_PKT, 32'd10);
    send_event(CMD_TICK, 32'd21);      // idle close, short-lived
    send_event(CMD_TICK, 32'd30);
    send_event(CMD_TICK, 32'd31);
    send_event(CMD_CONN_ERR, 32'd40);
    send_event(CMD_TICK, 32'd60);
    send_event(CMD_SOCK_ERR, 32'd200); // long-lived: backoff reset
    send_event(CMD_SOCK_ERR, 32'd200);
    // top of the time range: retry sum wraps, compare sums must not
    send_event(CMD_TICK, 32'hFFFF_FFF0);
    send_event(CMD_CONN_ERR, 32'hFFFF_FFFF);
    send_event(CMD_TICK, 32'hFFFF_FFFF);
    send_event(CMD_CONN_OK, 32'hFFFF_FFFF);
    send_event(CMD_TICK, 32'hFFFF_FFFF);
    send_event(CMD_SOCK_ERR, 32'd0);
  endtask

  // zero backoff: the first failure collapses the retry interval to zero
  task automatic zero_backoff_walk();
    send_event(CMD_TICK, 32'd1000);
    send_event(CMD_CONN_ERR, 32'd1001);
    send_event(CMD_TICK, 32'd1021);
    send_event(CMD_CONN_ERR, 32'd1022);
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    evt_ch.valid   = 1'b0;
    evt_ch.command = '0;
    evt_ch.now_s   = '0;
    res_ch.ready   = 1'b0;
    cycle_count    = 0;
    src_eager      = 1'b0;
    sink_eager     = 1'b0;
    hold_requests  = 0;
    hold_served    = 0;
    hold_left      = 0;
    run_left       = 0;
    t_now          = 32'd1022;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_walk();
    wait_drained();

    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0: load_config(12'd0, 12'd0);
        1: load_config(12'd4095, 12'd4095);
        2: load_config(12'd5, 12'd256);
        3: load_config(12'd4, 12'd384);
        4: load_config(12'd30, 12'd512);
        default: load_config(CfgW'($urandom), CfgW'($urandom));
      endcase
      if (p == 0) zero_backoff_walk();
      src_eager  = (p == 2);
      sink_eager = (p == 2);
      // fill the block against a stalled sink
      if (p == 1 || p == 4) begin
        src_eager = 1'b1;
        hold_requests++;
      end
      for (int n = 0; n < ItemsPerRun; n++) begin
        if (n % 50 == 49 && p != 2) begin
          src_eager  = ($urandom_range(0, 3) == 0);
          sink_eager = ($urandom_range(0, 3) == 0);
        end
        advance_clock();
        send_event(pick_command(), t_now);
      end
      wait_drained();
    end

    repeat (4) @(posedge clk_i);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
